FILE: rtl/core/ntlp_pkg.sv
`timescale 1ns / 1ps
package ntlp_pkg;

	typedef enum logic [1:0] {
		OP_UPSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_ROUTER = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RESERVED  = 2'd3
	} status_t;

	localparam int unsigned ID_W = 16;
	localparam int unsigned ROLE_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned SLOT_OUT_W = 6;
	localparam logic [7:0] ROUTER_ROLE_RESET = 8'd1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [ROLE_W-1:0] role;
		logic [WORD_W-1:0] position;
		logic [WORD_W-1:0] stamp;
	} record_t;

endpackage

FILE: rtl/core/ntlp_req_if.sv
`timescale 1ns / 1ps
interface ntlp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] node_id;
	logic [7:0]  role;
	logic [31:0] position;
	logic [31:0] timestamp;

	modport source (output valid, op, node_id, role, position, timestamp, input ready);
	modport sink (input valid, op, node_id, role, position, timestamp, output ready);
endinterface

FILE: rtl/core/ntlp_rsp_if.sv
`timescale 1ns / 1ps
interface ntlp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  slot_index;
	logic [15:0] found_id;
	logic [7:0]  found_role;
	logic [31:0] found_position;
	logic [31:0] found_time;

	modport source (output valid, status, slot_index, found_id, found_role, found_position,
		found_time, input ready);
	modport sink (input valid, status, slot_index, found_id, found_role, found_position,
		found_time, output ready);
endinterface

FILE: rtl/core/ntlp_store.sv
`timescale 1ns / 1ps
module ntlp_store
	import ntlp_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  record_t       wdata,
	input  logic [AW-1:0] raddr,
	output record_t       rdata,
	output logic          clearing
);
	record_t        mem [DEPTH];
	record_t        rd_q;
	logic [AW-1:0]  clr_q;
	logic           clr_busy_q;

	// one slot a cycle is zeroed after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) mem[clr_q] <= '0;
		else if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rdata    = rd_q;
	assign clearing = clr_busy_q;
endmodule

FILE: rtl/core/ntlp_mod.sv
`timescale 1ns / 1ps
module ntlp_mod
	import ntlp_pkg::*;
#(
	parameter int unsigned DIVISOR = 64,
	parameter int unsigned AW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [ID_W-1:0] key,
	output logic            done,
	output logic [AW-1:0]   rem
);
	localparam int unsigned SH = ID_W + AW;
	localparam int unsigned MW = ID_W + 2;
	localparam int unsigned PW = ID_W + MW;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / 64'(DIVISOR));
	localparam logic [AW:0] DIV = (AW+1)'(DIVISOR);

	logic [ID_W-1:0] key_q;
	logic [PW-1:0]   prod_q;
	logic [AW:0]     diff_q;
	logic [AW-1:0]   rem_q;
	logic [2:0]      stg_q;
	logic            done_q;
	logic [ID_W-1:0] quo;
	logic [ID_W-1:0] back;

	// quotient from a rounded-down reciprocal is at most one short
	assign quo  = ID_W'(prod_q >> SH);
	assign back = quo * ID_W'(DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q  <= '0;
			done_q <= 1'b0;
		end else begin
			stg_q  <= {stg_q[1:0], start};
			done_q <= stg_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (start) key_q <= key;
		if (stg_q[0]) prod_q <= PW'(key_q) * PW'(RECIP);
		if (stg_q[1]) diff_q <= (AW+1)'(key_q - back);
		if (stg_q[2]) rem_q <= (diff_q >= DIV) ? AW'(diff_q - DIV) : AW'(diff_q);
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

FILE: rtl/core/node_table_linear_probe.sv
`timescale 1ns / 1ps
// Node table of TABLE_SIZE slots with linear probing from node_id mod TABLE_SIZE; one
// request beat in, one response beat out, one request at a time. After reset the store is
// cleared one slot a cycle, so req.ready stays low until every slot is cleared. The home
// slot comes from a reciprocal-multiply remainder unit that registers the key, the product,
// the difference and the remainder in turn; then every probed slot takes a registered read
// of the single slot memory, then a compare, and the response beat holds until rsp.ready.
// A reserved id answers without a probe; find-router reads and compares each slot in turn
// from slot 0. Remove goes on, for each following cluster entry, to read it, find its home
// slot and probe for its new place, and then reads the empty slot that ends the cluster.
module node_table_linear_probe
	import ntlp_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	ntlp_req_if.sink   req,
	ntlp_rsp_if.source rsp
);
	localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [AW:0] N = (AW+1)'(TABLE_SIZE);
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MOD  = 11'b00000000010,
		S_FRD  = 11'b00000000100,
		S_FEV  = 11'b00000001000,
		S_CRD  = 11'b00000010000,
		S_CEV  = 11'b00000100000,
		S_PRD  = 11'b00001000000,
		S_PEV  = 11'b00010000000,
		S_RRD  = 11'b00100000000,
		S_REV  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t          state_q;
	logic [7:0]      router_q;
	op_t             op_q;
	record_t         new_q;
	record_t         mv_q;
	logic            reinsert_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   cptr_q;
	logic [AW:0]     cnt_q;
	logic [AW:0]     ccnt_q;
	status_t         res_status_q;
	logic [AW-1:0]   res_slot_q;
	record_t         res_rec_q;

	logic            mod_start;
	logic [ID_W-1:0] mod_key;
	logic            mod_done;
	logic [AW-1:0]   mod_rem;
	logic            we;
	logic [AW-1:0]   waddr;
	record_t         wdata;
	logic [AW-1:0]   raddr;
	record_t         ent;
	logic            store_clr;
	logic [AW-1:0]   addr_nx;
	logic [AW-1:0]   cptr_nx;
	logic [AW:0]     cnt_nx;
	logic [AW+5:0]   slot_ext;

	ntlp_mod #(.DIVISOR(TABLE_SIZE), .AW(AW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .key(mod_key),
		.done(mod_done), .rem(mod_rem)
	);

	ntlp_store #(.DEPTH(TABLE_SIZE), .AW(AW)) u_store (
		.clk(clk), .arst_n(arst_n), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(ent), .clearing(store_clr)
	);

	assign addr_nx = (addr_q == LAST) ? '0 : addr_q + AW'(1);
	assign cptr_nx = (cptr_q == LAST) ? '0 : cptr_q + AW'(1);
	assign cnt_nx  = cnt_q + (AW+1)'(1);
	assign raddr   = (state_q == S_CRD) ? cptr_q : addr_q;

	assign req.ready = (state_q == S_IDLE) && !store_clr;
	assign mod_start = (req.valid && req.ready && op_t'(req.op) != OP_ROUTER
		&& req.node_id != '0) || (state_q == S_CEV && ent.id != '0);
	assign mod_key = (state_q == S_IDLE) ? req.node_id : ent.id;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		unique case (state_q)
			S_FEV: begin
				if (ent.id == new_q.id || ent.id == '0) begin
					if (op_q == OP_UPSERT) begin
						we    = 1'b1;
						wdata = new_q;
					end else if (op_q == OP_REMOVE && ent.id != '0) begin
						we = 1'b1;
					end
				end
			end
			S_CEV: begin
				we    = (ent.id != '0);
				waddr = cptr_q;
			end
			S_PEV: begin
				we    = (ent.id == '0);
				wdata = mv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			router_q   <= ROUTER_ROLE_RESET;
			reinsert_q <= 1'b0;
		end else begin
			if (cfg_we) router_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						if (op_t'(req.op) == OP_ROUTER) state_q <= S_RRD;
						else if (req.node_id == '0) state_q <= S_OUT;
						else begin
							state_q    <= S_MOD;
							reinsert_q <= 1'b0;
						end
					end
				end
				S_MOD: if (mod_done) state_q <= reinsert_q ? S_PRD : S_FRD;
				S_FRD: state_q <= S_FEV;
				S_FEV: begin
					if (ent.id == new_q.id) begin
						state_q <= (op_q == OP_REMOVE) ? S_CRD : S_OUT;
					end else if (ent.id == '0 || cnt_nx == N) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_CRD: state_q <= S_CEV;
				S_CEV: begin
					if (ent.id == '0) state_q <= S_OUT;
					else begin
						state_q    <= S_MOD;
						reinsert_q <= 1'b1;
					end
				end
				S_PRD: state_q <= S_PEV;
				S_PEV: begin
					if (ent.id != '0) state_q <= S_PRD;
					else state_q <= (ccnt_q + (AW+1)'(1) == N) ? S_OUT : S_CRD;
				end
				S_RRD: state_q <= S_REV;
				S_REV: begin
					if ((ent.id != '0 && ent.role == router_q) || cnt_nx == N) state_q <= S_OUT;
					else state_q <= S_RRD;
				end
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(req.op);
				new_q  <= '{id: req.node_id, role: req.role, position: req.position,
					stamp: req.timestamp};
				addr_q <= '0;
				cnt_q  <= '0;
				res_status_q <= ST_RESERVED;
				res_slot_q   <= '0;
				res_rec_q    <= '0;
			end
			S_MOD: begin
				addr_q <= mod_rem;
				cnt_q  <= '0;
			end
			S_FEV: begin
				cnt_q  <= cnt_nx;
				addr_q <= addr_nx;
				if (ent.id == new_q.id || (ent.id == '0 && op_q == OP_UPSERT)) begin
					res_status_q <= ST_OK;
					res_slot_q   <= addr_q;
					res_rec_q    <= (op_q == OP_UPSERT) ? new_q : ent;
					cptr_q       <= addr_nx;
					cnt_q        <= (AW+1)'(1);
				end else if (ent.id == '0) begin
					res_status_q <= ST_NOT_FOUND;
				end else if (cnt_nx == N) begin
					res_status_q <= (op_q == OP_UPSERT) ? ST_FULL : ST_NOT_FOUND;
				end
			end
			S_CEV: mv_q <= ent;
			S_PEV: begin
				addr_q <= addr_nx;
				// cluster pointer kept apart from the probe position
				if (ent.id == '0) begin
					cptr_q <= cptr_nx;
				end
			end
			S_REV: begin
				cnt_q  <= cnt_nx;
				addr_q <= addr_nx;
				if (ent.id != '0 && ent.role == router_q) begin
					res_status_q <= ST_OK;
					res_slot_q   <= addr_q;
					res_rec_q    <= ent;
				end else if (cnt_nx == N) begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
	end

	// cluster step count lives in a counter of its own during removal
	always_ff @(posedge clk) begin
		if (state_q == S_FEV) ccnt_q <= (AW+1)'(1);
		else if (state_q == S_PEV && ent.id == '0) ccnt_q <= ccnt_q + (AW+1)'(1);
	end

	assign slot_ext = {6'd0, res_slot_q};
	assign rsp.valid          = (state_q == S_OUT);
	assign rsp.status         = res_status_q;
	assign rsp.slot_index     = slot_ext[SLOT_OUT_W-1:0];
	assign rsp.found_id       = res_rec_q.id;
	assign rsp.found_role     = res_rec_q.role;
	assign rsp.found_position = res_rec_q.position;
	assign rsp.found_time     = res_rec_q.stamp;
endmodule

FILE: rtl/core/ntlp_checker.sv
`timescale 1ns / 1ps
module ntlp_checker
	import ntlp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [5:0]  rsp_slot,
	input logic [15:0] rsp_id
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("request taken while response pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready stayed high after accept");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("response beat dropped or changed");

	a_ok_has_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_OK |-> rsp_id != 16'd0)
		else $error("ok response with empty record");

	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_id == 16'd0 && rsp_slot == 6'd0)
		else $error("failed response carries a record");
endmodule

bind node_table_linear_probe ntlp_checker u_ntlp_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
	.rsp_slot(rsp.slot_index), .rsp_id(rsp.found_id)
);
